// ----- src/grw_pkg.sv -----
package grw_pkg;

  localparam int MAP_SIZE     = 8;
  localparam int CELL_W       = 3;
  localparam int IDX_W        = 6;
  localparam int POS_W        = 15;
  localparam int FRAC_W       = 12;
  localparam int ANGLE_BITS   = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_IDX_W   = 4;
  localparam int CV_W         = 33;
  localparam int CZ_W         = 34;
  localparam int QUO_W        = 47;
  localparam int DVS_W        = 32;
  localparam int T_W          = 53;
  localparam int DQ_W         = 25;
  localparam int PERP_W       = 27;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 1;
  localparam int HH_W         = 10;
  localparam int OUT_W        = 16;
  localparam int CNT_W        = 6;
  localparam int DIV_STEPS    = QUO_W;
  localparam int COORD_W      = CELL_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_MAP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 1'b1;

  localparam logic signed [CV_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [QUO_W-1:0] STEP_CAP = {1'b1, {(QUO_W-1){1'b0}}};
  localparam logic [DQ_W-1:0]  DIST_CAP = {1'b1, {(DQ_W-1){1'b0}}};
  localparam logic [HH_W-1:0]  HH_RESET = 10'd240;

  typedef enum logic [1:0] {
    DIV_X = 2'd0,
    DIV_Y = 2'd1,
    DIV_S = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic                  load;
    logic                  cinit;
    logic                  csel_off;
    logic                  cstep;
    logic [STEP_IDX_W-1:0] cidx;
    logic                  cfin_a;
    logic                  cfin_b;
    logic                  div_ld;
    div_sel_t              div_sel;
    logic                  div_step;
    logic                  dnx_st;
    logic                  dny_st;
    logic                  mul_x;
    logic                  mul_y;
    logic                  dda_step;
    logic                  perp_st;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } stat_t;

  function automatic logic signed [CZ_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] i);
    logic signed [CZ_W-1:0] r;
    unique case (i)
      4'd0:    r = 34'sd536870912;
      4'd1:    r = 34'sd316933410;
      4'd2:    r = 34'sd167458907;
      4'd3:    r = 34'sd85004757;
      4'd4:    r = 34'sd42667331;
      4'd5:    r = 34'sd21354465;
      4'd6:    r = 34'sd10679838;
      4'd7:    r = 34'sd5340245;
      4'd8:    r = 34'sd2670163;
      4'd9:    r = 34'sd1335087;
      4'd10:   r = 34'sd667544;
      4'd11:   r = 34'sd333772;
      4'd12:   r = 34'sd166886;
      4'd13:   r = 34'sd83443;
      4'd14:   r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

  // arithmetic shift rounding toward zero
  function automatic logic signed [CV_W-1:0] shr_tz(input logic signed [CV_W-1:0] v,
                                                   input logic [STEP_IDX_W-1:0] n);
    logic signed [CV_W-1:0] m;
    m = v[CV_W-1] ? -v : v;
    m = m >>> n;
    return v[CV_W-1] ? -m : m;
  endfunction

endpackage

// ----- src/grw_if.sv -----
interface grw_in_if import grw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic [ANGLE_BITS-1:0]   heading;
  logic signed [ANGLE_BITS-1:0] ray_offset;

  modport source(output valid, pos_x, pos_y, heading, ray_offset, input ready);
  modport sink(input valid, pos_x, pos_y, heading, ray_offset, output ready);
endinterface

interface grw_out_if import grw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  distance;
  logic              hit_side;
  logic [CELL_W-1:0] hit_col;
  logic [CELL_W-1:0] hit_row;
  logic [OUT_W-1:0]  slice_height;
  logic              outside_map;

  modport source(output valid, distance, hit_side, hit_col, hit_row, slice_height,
                 outside_map, input ready);
  modport sink(input valid, distance, hit_side, hit_col, hit_row, slice_height,
               outside_map, output ready);
endinterface

// ----- src/grw_ctrl.sv -----
module grw_ctrl import grw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_CINIT_A = 18'h00002,
    S_CSTEP_A = 18'h00004,
    S_CFIN_A  = 18'h00008,
    S_DIVX_LD = 18'h00010,
    S_DIVX    = 18'h00020,
    S_DIVY_LD = 18'h00040,
    S_DIVY    = 18'h00080,
    S_MULX    = 18'h00100,
    S_MULY    = 18'h00200,
    S_DDA     = 18'h00400,
    S_CINIT_B = 18'h00800,
    S_CSTEP_B = 18'h01000,
    S_CFIN_B  = 18'h02000,
    S_PERP    = 18'h04000,
    S_DIVS_LD = 18'h08000,
    S_DIVS    = 18'h10000,
    S_FIN     = 18'h20000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;

  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] DDA_LAST    = CNT_W'(4 * MAP_SIZE - 1);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt + CNT_W'(1);
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.cidx       = cnt[STEP_IDX_W-1:0];
    cmd.div_sel    = DIV_X;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_CINIT_A;
      end
      S_CINIT_A: begin
        cmd.cinit  = 1'b1;
        cnt_next   = '0;
        state_next = S_CSTEP_A;
      end
      S_CSTEP_A: begin
        cmd.cstep = 1'b1;
        if (cnt == CORDIC_LAST) state_next = S_CFIN_A;
      end
      S_CFIN_A: begin
        cmd.cfin_a = 1'b1;
        state_next = S_DIVX_LD;
      end
      S_DIVX_LD: begin
        cmd.div_ld  = 1'b1;
        cmd.div_sel = DIV_X;
        cnt_next    = '0;
        state_next  = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = S_DIVY_LD;
      end
      S_DIVY_LD: begin
        cmd.dnx_st  = 1'b1;
        cmd.div_ld  = 1'b1;
        cmd.div_sel = DIV_Y;
        cnt_next    = '0;
        state_next  = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = S_MULX;
      end
      S_MULX: begin
        cmd.dny_st = 1'b1;
        cmd.mul_x  = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y  = 1'b1;
        cnt_next   = '0;
        state_next = S_DDA;
      end
      S_DDA: begin
        cmd.dda_step = 1'b1;
        if (stat.hit || cnt == DDA_LAST) state_next = S_CINIT_B;
      end
      S_CINIT_B: begin
        cmd.cinit    = 1'b1;
        cmd.csel_off = 1'b1;
        cnt_next     = '0;
        state_next   = S_CSTEP_B;
      end
      S_CSTEP_B: begin
        cmd.cstep = 1'b1;
        if (cnt == CORDIC_LAST) state_next = S_CFIN_B;
      end
      S_CFIN_B: begin
        cmd.cfin_b = 1'b1;
        state_next = S_PERP;
      end
      S_PERP: begin
        cmd.perp_st = 1'b1;
        state_next  = S_DIVS_LD;
      end
      S_DIVS_LD: begin
        cmd.div_ld  = 1'b1;
        cmd.div_sel = DIV_S;
        cnt_next    = '0;
        state_next  = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/grw_div.sv -----
module grw_div import grw_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [QUO_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quotient[QUO_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // restoring divider, one quotient bit per cycle while step is high
  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (step) begin
      rem      <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

endmodule

// ----- src/grw_dp.sv -----
module grw_dp import grw_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic [POS_W-1:0]             pos_x,
  input  logic [POS_W-1:0]             pos_y,
  input  logic [ANGLE_BITS-1:0]        heading,
  input  logic signed [ANGLE_BITS-1:0] ray_offset,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  output logic [OUT_W-1:0]             distance,
  output logic                         hit_side,
  output logic [CELL_W-1:0]            hit_col,
  output logic [CELL_W-1:0]            hit_row,
  output logic [OUT_W-1:0]             slice_height,
  output logic                         outside_map
);

  logic [CFG_W-1:0] wall_map;
  logic [HH_W-1:0]  half_height;

  logic [POS_W-1:0]      px, py;
  logic [ANGLE_BITS-1:0] ang, off;

  logic signed [CV_W-1:0] cx, cy, cos_v, sin_v, co;
  logic signed [CZ_W-1:0] cz;
  logic                   cflip;

  logic [QUO_W-1:0] dnx, dny;
  logic [T_W-1:0]   tns, twe, ray_len;
  logic [PERP_W-1:0] perp;
  logic signed [COORD_W-1:0] col, row;
  logic             side, outside;

  // cordic init
  logic [ANGLE_BITS-1:0] ang_sel;
  logic [31:0]           t0, t1, t2;
  logic                  flip0;
  logic signed [CV_W-1:0] xs, ys;

  assign ang_sel = cmd.csel_off ? off : ang;
  assign t0      = {ang_sel, {(32-ANGLE_BITS){1'b0}}};
  assign t1      = t0 + 32'h4000_0000;
  assign flip0   = t1[31];
  assign t2      = flip0 ? t0 - 32'h8000_0000 : t0;
  assign xs      = shr_tz(cx, cmd.cidx);
  assign ys      = shr_tz(cy, cmd.cidx);

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      cx    <= CORDIC_GAIN;
      cy    <= '0;
      cz    <= {{(CZ_W-32){t2[31]}}, t2};
      cflip <= flip0;
    end else if (cmd.cstep) begin
      if (!cz[CZ_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_turn(cmd.cidx);
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_turn(cmd.cidx);
      end
    end
    if (cmd.cfin_a) begin
      cos_v <= cflip ? -cx : cx;
      sin_v <= cflip ? -cy : cy;
    end
    if (cmd.cfin_b) co <= cflip ? -cx : cx;
  end

  // step lengths
  logic [DVS_W-1:0] c_mag, s_mag;
  logic [QUO_W-1:0] div_dvd, quo;
  logic [DVS_W-1:0] div_dvs;

  assign c_mag = cos_v[CV_W-1] ? DVS_W'(-cos_v) : DVS_W'(cos_v);
  assign s_mag = sin_v[CV_W-1] ? DVS_W'(-sin_v) : DVS_W'(sin_v);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_X: begin
        div_dvd = STEP_CAP;
        div_dvs = c_mag;
      end
      DIV_Y: begin
        div_dvd = STEP_CAP;
        div_dvs = s_mag;
      end
      default: begin
        div_dvd = QUO_W'({half_height, 16'b0});
        div_dvs = DVS_W'(perp);
      end
    endcase
  end

  grw_div u_div (
    .clk      (clk),
    .load     (cmd.div_ld),
    .step     (cmd.div_step),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (quo)
  );

  // start distances
  logic                  xpos, yup;
  logic [FRAC_W:0]       fxp, fyp, mul_b;
  logic [QUO_W-1:0]      mul_a;
  logic [QUO_W+FRAC_W:0] prod;

  assign xpos  = (ang[ANGLE_BITS-1:ANGLE_BITS-2] == 2'd0) ||
                 (ang[ANGLE_BITS-1:ANGLE_BITS-2] == 2'd3);
  assign yup   = !ang[ANGLE_BITS-1];
  assign fxp   = xpos ? (FRAC_W+1)'(1 << FRAC_W) - {1'b0, px[FRAC_W-1:0]}
                      : {1'b0, px[FRAC_W-1:0]};
  assign fyp   = yup ? {1'b0, py[FRAC_W-1:0]}
                     : (FRAC_W+1)'(1 << FRAC_W) - {1'b0, py[FRAC_W-1:0]};
  assign mul_a = cmd.mul_y ? dny : dnx;
  assign mul_b = cmd.mul_y ? fyp : fxp;
  assign prod  = mul_a * mul_b;

  // grid walk
  logic                      go_y, out_n;
  logic signed [COORD_W-1:0] ncol, nrow;
  logic [IDX_W-1:0]          cidx_map;
  localparam logic signed [COORD_W-1:0] MAP_LIM = COORD_W'(MAP_SIZE);

  assign go_y  = tns > twe;
  assign ncol  = go_y ? col : (xpos ? col + COORD_W'(1) : col - COORD_W'(1));
  assign nrow  = !go_y ? row : (yup ? row - COORD_W'(1) : row + COORD_W'(1));
  assign out_n = ncol[COORD_W-1] || ncol >= MAP_LIM || nrow[COORD_W-1] || nrow >= MAP_LIM;
  assign cidx_map = IDX_W'(MAP_SIZE) * IDX_W'(nrow[CELL_W-1:0]) + IDX_W'(ncol[CELL_W-1:0]);
  assign stat.hit = out_n || wall_map[cidx_map];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px  <= pos_x;
      py  <= pos_y;
      off <= ray_offset;
      ang <= heading + ray_offset;
    end
    if (cmd.dnx_st) dnx <= (c_mag == '0) ? STEP_CAP : quo;
    if (cmd.dny_st) dny <= (s_mag == '0) ? STEP_CAP : quo;
    if (cmd.mul_x) begin
      tns <= T_W'(prod >> FRAC_W);
      col <= COORD_W'(px[POS_W-1:FRAC_W]);
      row <= COORD_W'(py[POS_W-1:FRAC_W]);
    end
    if (cmd.mul_y) twe <= T_W'(prod >> FRAC_W);
    if (cmd.dda_step) begin
      col     <= ncol;
      row     <= nrow;
      side    <= go_y;
      outside <= out_n;
      if (go_y) begin
        ray_len <= twe;
        twe     <= twe + T_W'(dny);
      end else begin
        ray_len <= tns;
        tns     <= tns + T_W'(dnx);
      end
    end
  end

  // perpendicular distance and slice
  logic [DQ_W-1:0]       dq;
  logic [DQ_W+DVS_W-1:0] pprod;

  assign dq    = (ray_len > T_W'(DIST_CAP)) ? DIST_CAP : ray_len[DQ_W-1:0];
  assign pprod = dq * co[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.perp_st) perp <= pprod[DQ_W+DVS_W-1:30];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      distance <= (|ray_len[T_W-1:OUT_W+4]) ? '1 : ray_len[OUT_W+3:4];
      hit_side <= side;
      outside_map <= outside;
      hit_col  <= col[COORD_W-1] ? '0 : (col >= MAP_LIM ? CELL_W'(MAP_SIZE-1) : col[CELL_W-1:0]);
      hit_row  <= row[COORD_W-1] ? '0 : (row >= MAP_LIM ? CELL_W'(MAP_SIZE-1) : row[CELL_W-1:0]);
      if (co[CV_W-1]) slice_height <= '0;
      else if (perp == '0) slice_height <= '1;
      else if (|quo[QUO_W-1:OUT_W]) slice_height <= '1;
      else slice_height <= quo[OUT_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map    <= '0;
      half_height <= HH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WALL_MAP:    wall_map <= cfg_data;
        REG_HALF_HEIGHT: half_height <= cfg_data[HH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/grid_ray_wall_distance.sv -----
// one ray is worked at a time; the grid walk takes 1 to 32 steps, ending at the first wall or map exit
// each ray runs two 16-step cordic passes and three 47-bit restoring divisions in a shared
// bit-serial divider; a new ray is accepted only once the last one has reached the output register
// the next item is taken while a finished result waits in the output register
// reset: synchronous active-high rst clears the controller, wall_map to 0, half_height to 240
module grid_ray_wall_distance import grw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  grw_in_if.sink               in_ch,
  grw_out_if.source            out_ch
);

  cmd_t  cmd;
  stat_t stat;

  grw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  grw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (in_ch.pos_x),
    .pos_y        (in_ch.pos_y),
    .heading      (in_ch.heading),
    .ray_offset   (in_ch.ray_offset),
    .cmd          (cmd),
    .stat         (stat),
    .distance     (out_ch.distance),
    .hit_side     (out_ch.hit_side),
    .hit_col      (out_ch.hit_col),
    .hit_row      (out_ch.hit_row),
    .slice_height (out_ch.slice_height),
    .outside_map  (out_ch.outside_map)
  );

endmodule

// ----- tb/sv/grid_ray_wall_distance_tb.sv -----
module grid_ray_wall_distance_tb;
  import grw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OUT_W-1:0]  distance;
    logic              hit_side;
    logic [CELL_W-1:0] hit_col;
    logic [CELL_W-1:0] hit_row;
    logic [OUT_W-1:0]  slice_height;
    logic              outside_map;
  } ray_hit_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 900;
  localparam longint unsigned STEP_LIMIT = 64'd1 << 46;
  localparam longint unsigned DIST_LIMIT = 64'd1 << 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WALL_MAP;
  logic [CFG_W-1:0] cfg_data = '0;

  grw_in_if  in_ch ();
  grw_out_if out_ch ();

  grid_ray_wall_distance u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  logic [63:0] map_bits = 64'd0;
  logic [HH_W-1:0] scale_hh = 10'd240;
  ray_hit_t hits_pending[$];
  int mismatches = 0;
  int rays_sent = 0;
  int hits_seen = 0;
  int idle_cnt = 0;
  bit gaps_on = 1'b1;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int rx_wait = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.heading = '0;
    in_ch.ray_offset = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint shr_zero(longint v, int n);
    if (v < 0) return -((-v) >>> n);
    return v >>> n;
  endfunction

  function automatic void rotate(input logic [ANGLE_BITS-1:0] ang, output longint cs,
                                 output longint sn);
    logic [31:0] t;
    bit flip;
    longint x, y, z, xs, ys;
    t = {ang, 20'd0};
    flip = ((t + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) t = t - 32'h8000_0000;
    z = longint'($signed(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr_zero(x, i);
      ys = shr_zero(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(i[STEP_IDX_W-1:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(i[STEP_IDX_W-1:0]));
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint unsigned cell_step(longint v);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    if (m == 0) return STEP_LIMIT;
    r = STEP_LIMIT / m;
    return (r > STEP_LIMIT) ? STEP_LIMIT : r;
  endfunction

  function automatic ray_hit_t cast_ray(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                        logic [ANGLE_BITS-1:0] hd, logic [ANGLE_BITS-1:0] off);
    ray_hit_t r;
    logic [ANGLE_BITS-1:0] ang;
    logic [1:0] q;
    longint c, s, co, sd;
    longint unsigned dnx, dny, tns, twe, ray_len, dq, perp, slice, fx, fy;
    int xi, yi, col, row;
    bit hit, outside, side;
    ang = hd + off;
    q = ang[ANGLE_BITS-1 -: 2];
    rotate(ang, c, s);
    dnx = cell_step(c);
    dny = cell_step(s);
    fx = px[FRAC_W-1:0];
    fy = py[FRAC_W-1:0];
    xi = (q == 0 || q == 3) ? 1 : -1;
    yi = (q < 2) ? -1 : 1;
    tns = (dnx * (xi > 0 ? 4096 - fx : fx)) >> 12;
    twe = (dny * (yi < 0 ? fy : 4096 - fy)) >> 12;
    col = px >> FRAC_W;
    row = py >> FRAC_W;
    hit = 0; outside = 0; side = 0; ray_len = 0;
    for (int i = 0; i < 4 * MAP_SIZE && !hit; i++) begin
      if (tns > twe) begin
        row += yi; side = 1; ray_len = twe; twe += dny;
      end else begin
        col += xi; side = 0; ray_len = tns; tns += dnx;
      end
      if (col < 0 || col >= MAP_SIZE || row < 0 || row >= MAP_SIZE) begin
        outside = 1; hit = 1;
      end else begin
        hit = map_bits[row * MAP_SIZE + col];
      end
    end
    r.distance = ((ray_len >> 4) > 65535) ? 16'hFFFF : ray_len[19:4];
    r.hit_side = side;
    r.hit_col = (col < 0) ? 3'd0 : (col >= MAP_SIZE) ? 3'd7 : col[2:0];
    r.hit_row = (row < 0) ? 3'd0 : (row >= MAP_SIZE) ? 3'd7 : row[2:0];
    rotate(off, co, sd);
    if (co < 0) begin
      slice = 0;
    end else begin
      dq = (ray_len > DIST_LIMIT) ? DIST_LIMIT : ray_len;
      perp = (dq * longint'(co)) >> 30;
      if (perp == 0) slice = 65535;
      else begin
        slice = (longint'(scale_hh) << 16) / perp;
        if (slice > 65535) slice = 65535;
      end
    end
    r.slice_height = slice[15:0];
    r.outside_map = outside;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WALL_MAP) map_bits = val;
    else scale_hh = val[HH_W-1:0];
  endtask

  task automatic cast(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                      logic [ANGLE_BITS-1:0] hd, logic [ANGLE_BITS-1:0] off);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.heading <= hd;
    in_ch.ray_offset <= off;
    do @(posedge clk); while (!in_ch.ready);
    hits_pending.push_back(cast_ray(px, py, hd, off));
    rays_sent++;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cast_random();
    cast(POS_W'($urandom_range(0, 32767)), POS_W'($urandom_range(0, 32767)),
         ANGLE_BITS'($urandom_range(0, 4095)), ANGLE_BITS'($urandom_range(0, 4095)));
  endtask

  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_cnt <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.ready && out_ch.valid) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      out_ch.ready <= (gap == 0);
      rx_wait <= (gap > 0) ? gap - 1 : 0;
    end else if (!out_ch.ready) begin
      if (rx_wait == 0) out_ch.ready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  always @(posedge clk) begin
    ray_hit_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      hits_seen++;
      if (hits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = hits_pending.pop_front();
        if (out_ch.distance !== want.distance || out_ch.hit_side !== want.hit_side ||
            out_ch.hit_col !== want.hit_col || out_ch.hit_row !== want.hit_row ||
            out_ch.slice_height !== want.slice_height ||
            out_ch.outside_map !== want.outside_map) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp d=%0d s=%0d c=%0d r=%0d h=%0d o=%0d got %0d %0d %0d %0d %0d %0d",
                     want.distance, want.hit_side, want.hit_col, want.hit_row,
                     want.slice_height, want.outside_map, out_ch.distance, out_ch.hit_side,
                     out_ch.hit_col, out_ch.hit_row, out_ch.slice_height, out_ch.outside_map);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    cast(15'h4800, 15'h4800, 12'd0, 12'd0);
    cast(15'd0, 15'd0, 12'd512, 12'd0);
    drain();
  endtask

  task automatic test_axes_and_extremes();
    write_reg(REG_WALL_MAP, 64'h8142_2418_1824_4281);
    cast(15'h3800, 15'h3800, 12'd0, 12'd0);
    cast(15'h3800, 15'h3800, 12'd1024, 12'd0);
    cast(15'h3800, 15'h3800, 12'd2048, 12'd0);
    cast(15'h3800, 15'h3800, 12'd3072, 12'd0);
    cast(15'd0, 15'd0, 12'd4095, 12'h800);
    cast(15'h7FFF, 15'h7FFF, 12'd1500, 12'h7FF);
    cast(15'h2000, 15'h2000, 12'd2048, 12'h400);
    cast(15'h2000, 15'h2000, 12'd100, 12'hC00);
    cast(15'h3000, 15'h3123, 12'd2048, 12'd0);
    drain();
  endtask

  task automatic test_scale_and_full_map();
    write_reg(REG_HALF_HEIGHT, 10'd0);
    write_reg(REG_WALL_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
    cast(15'h4321, 15'h5678, 12'd300, 12'd50);
    cast(15'h0FFF, 15'h7000, 12'd3000, 12'hF00);
    drain();
    write_reg(REG_HALF_HEIGHT, 10'd1023);
    cast(15'h4321, 15'h5678, 12'd300, 12'd50);
    cast(15'h0800, 15'h0800, 12'd3500, 12'd0);
    drain();
    write_reg(REG_WALL_MAP, 64'd0);
    cast(15'h0800, 15'h0800, 12'd700, 12'd0);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 9; ph++) begin
      gaps_on = (ph % 3) != 2;
      write_reg(REG_WALL_MAP, (ph % 2) ? {$urandom(), $urandom()}
                                        : {$urandom() & $urandom(), $urandom() & $urandom()});
      write_reg(REG_HALF_HEIGHT, (ph == 4) ? 10'd1023 : (ph == 6) ? 10'd0 : $urandom_range(1, 1023));
      repeat (200) cast_random();
      drain();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_output_stall();
    hold_token++;
    repeat (20) cast_random();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_axes_and_extremes();
    test_scale_and_full_map();
    test_random_phases();
    test_output_stall();
    repeat (300) @(posedge clk);
    $display("cast %0d rays over several map and scale settings, checked %0d results",
             rays_sent, hits_seen);
    if (mismatches == 0 && hits_pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("mismatches: %0d, results still expected: %0d", mismatches, hits_pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- grid_ray_wall_distance.f -----
src/grw_pkg.sv
src/grw_if.sv
src/grw_ctrl.sv
src/grw_div.sv
src/grw_dp.sv
src/grid_ray_wall_distance.sv
tb/sv/grid_ray_wall_distance_tb.sv
